// File: hw/rtl/sha256_stream_hasher_defines.svh
// ----------------------------------------------------------------------------
// sha256_stream_hasher_defines.svh
// Assertion macros shared by the hasher RTL.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SSH_ASSERT_IMP(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("ssh assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SSH_ASSERT_NXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("ssh assertion failed");

`endif

// File: hw/rtl/ssh_pkg.sv
// ----------------------------------------------------------------------------
// ssh_pkg
// Types, constants and round functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package ssh_pkg;

	localparam int TOTAL_W = 61;
	localparam int ROUNDS  = 64;

	// request command codes
	localparam logic [1:0] CMD_ABSORB  = 2'd0;
	localparam logic [1:0] CMD_DIGEST  = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	// result kinds
	localparam logic KIND_DIGEST = 1'b0;
	localparam logic KIND_REJECT = 1'b1;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam int         LEN_POS  = 56;

	// how the schedule window is loaded from the block buffer
	typedef enum logic [1:0] {
		LD_RAW,
		LD_PAD,
		LD_LEN
	} ld_mode_t;

	typedef struct packed {
		logic      wr_byte;
		logic      restart;
		logic      ld;
		ld_mode_t  ld_mode;
		logic      ld_chain;
		logic      rnd;
		logic [5:0] rnd_idx;
		logic      fin;
		logic      commit;
		logic      emit_ld;
		logic [2:0] emit_idx;
		logic      emit_last;
		logic      reject_ld;
	} ctrl_cmd_t;

	typedef struct packed {
		logic at_limit;
		logic blk_last;
		logic two_blk;
		logic out_free;
	} dp_sts_t;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] K_TAB [ROUNDS] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] sml_s0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sml_s1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// File: hw/rtl/ssh_datapath.sv
// ----------------------------------------------------------------------------
// ssh_datapath
// Block buffer, byte counts, message schedule, round unit, chaining state
// and the result register.
// ----------------------------------------------------------------------------
module ssh_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ssh_pkg::ctrl_cmd_t cmd,
	output ssh_pkg::dp_sts_t   sts,
	input  logic [7:0]        data_byte,
	output logic              result_valid,
	input  logic              result_ready,
	output logic              kind,
	output logic [31:0]       digest_word,
	output logic              last_word
);
	import ssh_pkg::*;

	logic [31:0]        buf_q   [16];
	logic [31:0]        sched_q [16];
	logic [31:0]        work_q  [8];
	logic [31:0]        base_q  [8];
	logic [31:0]        chain_q [8];
	logic [5:0]         count_q;
	logic [TOTAL_W-1:0] total_q;
	logic               out_valid_q;
	logic               kind_q;
	logic [31:0]        word_q;
	logic               last_q;

	logic [31:0] blk      [16];
	logic [63:0] bit_len;
	logic [31:0] t1, t2, w_new;
	logic [31:0] sum      [8];

	// status toward the controller
	assign sts.at_limit = &total_q;
	assign sts.blk_last = &count_q;
	assign sts.two_blk  = (count_q >= 6'(LEN_POS));
	assign sts.out_free = !out_valid_q || result_ready;

	// block image for the schedule window: raw, padded, or length-only
	assign bit_len = {total_q, 3'b000};
	always_comb begin
		logic [5:0] pos;
		logic [7:0] b;
		for (int k = 0; k < 16; k++) begin
			for (int j = 0; j < 4; j++) begin
				pos = 6'(4 * k + j);
				b   = buf_q[k][8*(3-j) +: 8];
				case (cmd.ld_mode)
					LD_RAW: ;
					LD_PAD: begin
						if (pos < count_q) b = b;
						else if (pos == count_q) b = PAD_MARK;
						else if (count_q < 6'(LEN_POS) && pos >= 6'(LEN_POS))
							b = bit_len[8*(63-(4*k+j)) +: 8];
						else b = '0;
					end
					LD_LEN: begin
						if (pos >= 6'(LEN_POS)) b = bit_len[8*(63-(4*k+j)) +: 8];
						else b = '0;
					end
					default: b = '0;
				endcase
				blk[k][8*(3-j) +: 8] = b;
			end
		end
	end

	// one round and one schedule step
	assign t1 = work_q[7] + big_s1(work_q[4])
		+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
		+ K_TAB[cmd.rnd_idx] + sched_q[0];
	assign t2 = big_s0(work_q[0])
		+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
	assign w_new = sml_s1(sched_q[14]) + sched_q[9] + sml_s0(sched_q[1]) + sched_q[0];

	always_comb begin
		for (int i = 0; i < 8; i++) sum[i] = base_q[i] + work_q[i];
	end

	// block buffer: bytes land in their word lane, no reset
	always_ff @(posedge clk) begin
		if (cmd.wr_byte) begin
			buf_q[count_q[5:2]][8*(3-count_q[1:0]) +: 8] <= data_byte;
		end
	end

	// schedule window and working variables
	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			for (int i = 0; i < 16; i++) sched_q[i] <= blk[i];
			for (int i = 0; i < 8; i++) work_q[i] <= cmd.ld_chain ? chain_q[i] : base_q[i];
		end else if (cmd.rnd) begin
			for (int i = 0; i < 15; i++) sched_q[i] <= sched_q[i+1];
			sched_q[15] <= w_new;
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
		end
	end

	// base of the running compression
	always_ff @(posedge clk) begin
		if (cmd.ld && cmd.ld_chain) begin
			for (int i = 0; i < 8; i++) base_q[i] <= chain_q[i];
		end else if (cmd.fin) begin
			for (int i = 0; i < 8; i++) base_q[i] <= sum[i];
		end
	end

	// chaining state and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= H_INIT[i];
			count_q <= '0;
			total_q <= '0;
		end else begin
			if (cmd.restart) begin
				for (int i = 0; i < 8; i++) chain_q[i] <= H_INIT[i];
				count_q <= '0;
				total_q <= '0;
			end else begin
				if (cmd.fin && cmd.commit) begin
					for (int i = 0; i < 8; i++) chain_q[i] <= sum[i];
				end
				if (cmd.wr_byte) begin
					count_q <= count_q + 6'd1;
					total_q <= total_q + TOTAL_W'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_ld || cmd.reject_ld) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			kind_q <= KIND_DIGEST;
			word_q <= base_q[cmd.emit_idx];
			last_q <= cmd.emit_last;
		end else if (cmd.reject_ld) begin
			kind_q <= KIND_REJECT;
			word_q <= '0;
			last_q <= 1'b1;
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = kind_q;
	assign digest_word  = word_q;
	assign last_word    = last_q;

endmodule

// File: hw/rtl/ssh_ctrl.sv
// ----------------------------------------------------------------------------
// ssh_ctrl
// Sequencer: request decode, block load, 64 rounds, finish, digest emit.
// ----------------------------------------------------------------------------
module ssh_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [1:0]         command,
	input  ssh_pkg::dp_sts_t   sts,
	output ssh_pkg::ctrl_cmd_t cmd
);
	import ssh_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FINISH,
		ST_EMIT
	} state_t;

	state_t     state_q;
	logic [5:0] rnd_q;
	logic [2:0] idx_q;
	logic       dig_q;
	logic       two_q;
	logic       first_q;
	logic       accept;

	assign item_ready = (state_q == ST_IDLE) && sts.out_free;
	assign accept     = item_valid && item_ready;

	// commands to the datapath
	always_comb begin
		cmd           = '0;
		cmd.ld_mode   = LD_RAW;
		cmd.rnd_idx   = rnd_q;
		cmd.emit_idx  = idx_q;
		cmd.emit_last = &idx_q;
		cmd.commit    = !dig_q;
		cmd.ld_chain  = first_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (command)
						CMD_ABSORB: begin
							cmd.wr_byte   = !sts.at_limit;
							cmd.reject_ld = sts.at_limit;
						end
						CMD_RESTART: cmd.restart = 1'b1;
						default: ;
					endcase
				end
			end
			ST_LOAD: begin
				cmd.ld = 1'b1;
				if (!first_q) cmd.ld_mode = LD_LEN;
				else if (dig_q) cmd.ld_mode = LD_PAD;
				else cmd.ld_mode = LD_RAW;
			end
			ST_ROUND:  cmd.rnd = 1'b1;
			ST_FINISH: cmd.fin = 1'b1;
			ST_EMIT:   cmd.emit_ld = sts.out_free;
			default: ;
		endcase
	end

	// state and sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			idx_q   <= '0;
			dig_q   <= 1'b0;
			two_q   <= 1'b0;
			first_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					first_q <= 1'b1;
					if (accept && command == CMD_ABSORB && !sts.at_limit && sts.blk_last) begin
						dig_q   <= 1'b0;
						two_q   <= 1'b0;
						state_q <= ST_LOAD;
					end else if (accept && command == CMD_DIGEST) begin
						dig_q   <= 1'b1;
						two_q   <= sts.two_blk;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (&rnd_q) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (dig_q && two_q) begin
						two_q   <= 1'b0;
						first_q <= 1'b0;
						state_q <= ST_LOAD;
					end else if (dig_q) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						idx_q <= idx_q + 3'd1;
						if (&idx_q) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream with absorb, digest and restart requests.
//
//   channel  handshake                  payload
//   item     item_valid / item_ready    command, data_byte
//   result   result_valid / result_ready kind, digest_word, last_word
//
// The 64th byte of a block starts a compression (load, 64 rounds
// through one shared round unit, finish).
// A digest compresses one or two padded blocks, then emits 8 words.
// After reset the initial hash value is loaded and counts are zero.
// Requests wait while a block is compressed or digest words are pending.
// A full result register stalls emission until result_ready.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        kind,
	output logic [31:0] digest_word,
	output logic        last_word
);
	import ssh_pkg::*;

	`include "sha256_stream_hasher_defines.svh"

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	ssh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.command    (command),
		.sts        (sts),
		.cmd        (cmd)
	);

	ssh_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.data_byte    (data_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kind         (kind),
		.digest_word  (digest_word),
		.last_word    (last_word)
	);

	// a digest request keeps the sequencer busy on the next cycle
	`SSH_ASSERT_NXT(a_digest_busy, clk, arst_n, item_valid && item_ready && command == CMD_DIGEST, !item_ready)
	// a rejected byte is always a single, final, zero result
	`SSH_ASSERT_IMP(a_reject_last, clk, arst_n, result_valid && kind == KIND_REJECT, last_word && digest_word == '0)
	// no round while new requests are taken
	`SSH_ASSERT_IMP(a_round_idle, clk, arst_n, cmd.rnd || cmd.ld || cmd.fin, !item_ready)

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SHA-256 stream hasher. Requests (absorb, digest,
// restart and the unused code) are driven with random gaps. Each accepted
// request updates a software SHA-256 state that predicts the digest words.
// Each returned word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	import ssh_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam longint unsigned MAX_BYTES = 64'h1FFF_FFFF_FFFF_FFFF;
	localparam int STALL_LIMIT = 5000;

	// running SHA-256 state and queue of predicted digest words
	class Sha256Tracker;
		bit [31:0] chain[8];
		bit [7:0]  blk_bytes[64];
		int unsigned nbytes;
		longint unsigned total;
		bit [31:0] word_q[$];
		bit        kind_q[$];
		bit        last_q[$];
		int        errors;

		function new();
			restart();
			errors = 0;
		endfunction

		function void restart();
			for (int i = 0; i < 8; i++)
				chain[i] = H_INIT[i];
			nbytes = 0;
			total = 0;
		endfunction

		function bit [31:0] ror(bit [31:0] v, int n);
			return (v >> n) | (v << (32 - n));
		endfunction

		// one 64-round compression of a 64-byte block into h
		function void compress(ref bit [31:0] h[8], input bit [7:0] b[64]);
			bit [31:0] w[64];
			bit [31:0] a, bb, c, d, e, f, g, hh, t1, t2, s0, s1;
			for (int i = 0; i < 16; i++)
				w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
			for (int i = 16; i < 64; i++) begin
				s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = s1 + w[i-7] + s0 + w[i-16];
			end
			a = h[0]; bb = h[1]; c = h[2]; d = h[3];
			e = h[4]; f = h[5]; g = h[6]; hh = h[7];
			for (int i = 0; i < 64; i++) begin
				t1 = hh + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
					+ K_TAB[i] + w[i];
				t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & bb) ^ (a & c) ^ (bb & c));
				hh = g; g = f; f = e; e = d + t1;
				d = c; c = bb; bb = a; a = t1 + t2;
			end
			h[0] += a; h[1] += bb; h[2] += c; h[3] += d;
			h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
		endfunction

		function void push(bit k, bit [31:0] w, bit l);
			kind_q.push_back(k);
			word_q.push_back(w);
			last_q.push_back(l);
		endfunction

		// update state for one accepted request
		function void note_request(bit [1:0] cmd, bit [7:0] data);
			bit [31:0] h[8];
			bit [7:0]  pad[64];
			bit [63:0] bits;
			int unsigned n;
			case (cmd)
				CMD_ABSORB: begin
					if (total >= MAX_BYTES) begin
						push(KIND_REJECT, 32'h0, 1'b1);
					end else begin
						total++;
						blk_bytes[nbytes] = data;
						nbytes++;
						if (nbytes == 64) begin
							compress(chain, blk_bytes);
							nbytes = 0;
						end
					end
				end
				CMD_DIGEST: begin
					h = chain;
					for (int i = 0; i < 64; i++)
						pad[i] = (i < nbytes) ? blk_bytes[i] : 8'h00;
					n = nbytes;
					pad[n] = PAD_MARK;
					n++;
					if (n > LEN_POS) begin
						compress(h, pad);
						for (int i = 0; i < 64; i++)
							pad[i] = 8'h00;
					end
					bits = total * 8;
					for (int i = 0; i < 8; i++)
						pad[LEN_POS + i] = bits[63 - 8*i -: 8];
					compress(h, pad);
					for (int i = 0; i < 8; i++)
						push(KIND_DIGEST, h[i], i == 7);
				end
				CMD_RESTART: restart();
				default: ;
			endcase
		endfunction

		function void check_result(bit k, bit [31:0] w, bit l);
			bit ek, el;
			bit [31:0] ew;
			if (word_q.size() == 0) begin
				$error("unexpected result kind=%0d word=%h last=%0d", k, w, l);
				errors++;
				return;
			end
			ek = kind_q.pop_front();
			ew = word_q.pop_front();
			el = last_q.pop_front();
			if (k !== ek) begin
				$error("kind: expected %0d actual %0d", ek, k);
				errors++;
			end
			if (w !== ew) begin
				$error("digest_word: expected %h actual %h", ew, w);
				errors++;
			end
			if (l !== el) begin
				$error("last_word: expected %0d actual %0d", el, l);
				errors++;
			end
		endfunction

		function int pending();
			return word_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic [1:0]  command;
	logic [7:0]  data_byte;
	logic        result_valid;
	logic        result_ready;
	logic        kind;
	logic [31:0] digest_word;
	logic        last_word;

	Sha256Tracker sb;
	int send_idle;
	int recv_idle;
	int stall_cnt;

	sha256_stream_hasher DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.command(command), .data_byte(data_byte),
		.result_valid(result_valid), .result_ready(result_ready),
		.kind(kind), .digest_word(digest_word), .last_word(last_word)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	// track accepted requests and check results
	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready)
			sb.note_request(command, data_byte);
		if (arst_n && result_valid && result_ready)
			sb.check_result(kind, digest_word, last_word);
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// drive one request, with an optional random gap before it
	task automatic send(input logic [1:0] cmd, input logic [7:0] data);
		while ($urandom_range(0, 99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		command <= cmd;
		data_byte <= data;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic send_msg(input string s);
		for (int i = 0; i < s.len(); i++)
			send(CMD_ABSORB, s[i]);
	endtask

	// hold the sender until every predicted result has come back
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// random request mix: mostly message bytes
	task automatic random_phase(input int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 86)
				send(CMD_ABSORB, 8'($urandom_range(0, 255)));
			else if (r < 93)
				send(CMD_DIGEST, 8'($urandom_range(0, 255)));
			else if (r < 97)
				send(CMD_RESTART, 8'($urandom_range(0, 255)));
			else
				send(CMD_UNUSED, 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		command = CMD_ABSORB;
		data_byte = 8'h00;
		result_ready = 1'b0;
		stall_cnt = 0;
		send_idle = 0;
		recv_idle = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, unused code, "abc", extreme bytes, restart mid-message
		send(CMD_DIGEST, 8'hFF);
		send(CMD_UNUSED, 8'hA5);
		send_msg("abc");
		send(CMD_DIGEST, 8'h00);
		send(CMD_DIGEST, 8'h5A);
		send(CMD_ABSORB, 8'h00);
		send(CMD_ABSORB, 8'hFF);
		send(CMD_RESTART, 8'hFF);
		send(CMD_ABSORB, 8'hFF);
		send(CMD_DIGEST, 8'h00);
		send(CMD_RESTART, 8'h00);

		// let everything drain before the padding boundary cases
		drain();

		// 55 bytes fits one padded block, 56 needs two, 64 fills a block
		for (int i = 0; i < 55; i++)
			send(CMD_ABSORB, 8'(i));
		send(CMD_DIGEST, 8'h00);
		send(CMD_ABSORB, 8'h37);
		send(CMD_DIGEST, 8'h00);
		for (int i = 56; i < 64; i++)
			send(CMD_ABSORB, 8'(~i));
		send(CMD_DIGEST, 8'h00);
		send(CMD_RESTART, 8'h00);

		send_idle = 24; recv_idle = 70;
		random_phase(126);
		send_idle = 70; recv_idle = 24;
		random_phase(126);
		send_idle = 0; recv_idle = 0;
		random_phase(126);
		send(CMD_DIGEST, 8'h00);

		drain();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
